// ===== hdl/avr_pkg.sv =====
// Package for the axis-angle vector rotator: shared types, register codes and
// the fixed-point rounding and saturation helpers. No dependencies.

package avr_pkg;

   localparam int BUILD_STAGES = 5;
   localparam int BUILD_CNT_W  = $clog2(BUILD_STAGES + 1);
   localparam int ADDR_W       = 5;
   localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

   typedef enum logic [2:0] {
      REG_SINE   = 3'd0,
      REG_COSINE = 3'd1,
      REG_AXIS_X = 3'd2,
      REG_AXIS_Y = 3'd3,
      REG_AXIS_Z = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] axis_z;
      logic signed [31:0] axis_y;
      logic signed [31:0] axis_x;
      logic signed [31:0] cosine;
      logic signed [31:0] sine;
   } cfg_type;

   // Rotation matrix, indexed [row][column], Q1.30 terms.
   typedef logic [2:0][2:0][31:0] mat_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } pipe_status_type;

   function automatic logic signed [35:0] ext32(input logic signed [31:0] v);
      return {{4{v[31]}}, v};
   endfunction

   function automatic logic signed [35:0] ext34(input logic signed [33:0] v);
      return {{2{v[33]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -36'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Round to nearest, ties toward positive infinity, then drop 30 fraction bits.
   function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd536870912;
      return t[63:30];
   endfunction

   function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
      return sat32(ext34(rnd30(p)));
   endfunction

endpackage

// ===== hdl/avr_csr.sv =====
// Configuration register file with an APB-style access port.
// Depends on avr_pkg for the register codes and the configuration struct.

module avr_csr import avr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output cfg_type             cfg,
   output logic                cfg_write
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (index)
            REG_SINE:   cfg_in.sine   = csr_pwdata;
            REG_COSINE: cfg_in.cosine = csr_pwdata;
            REG_AXIS_X: cfg_in.axis_x = csr_pwdata;
            REG_AXIS_Y: cfg_in.axis_y = csr_pwdata;
            REG_AXIS_Z: cfg_in.axis_z = csr_pwdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SINE:   csr_prdata = cfg_ff.sine;
         REG_COSINE: csr_prdata = cfg_ff.cosine;
         REG_AXIS_X: csr_prdata = cfg_ff.axis_x;
         REG_AXIS_Y: csr_prdata = cfg_ff.axis_y;
         REG_AXIS_Z: csr_prdata = cfg_ff.axis_z;
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sine   <= 32'sd0;
         cfg_ff.cosine <= 32'sd1073741824;
         cfg_ff.axis_x <= 32'sd0;
         cfg_ff.axis_y <= 32'sd0;
         cfg_ff.axis_z <= 32'sd1073741824;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/avr_matrix.sv =====
// Five-stage pipeline that builds the Rodrigues rotation matrix from the
// configuration registers. Depends on avr_pkg.

module avr_matrix import avr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cfg_write,
   output mat_type mat,
   output logic    mat_ready
);

   logic signed [31:0]    omc_in, omc_ff;
   logic signed [63:0]    sq_in [6], sq_ff [6];
   logic signed [63:0]    skp_in [3], skp_ff [3];
   logic signed [31:0]    q_in [6], q_ff [6];
   logic signed [31:0]    k2_in [3], k2_ff [3];
   logic signed [63:0]    symp_in [6], symp_ff [6];
   logic signed [31:0]    k3_ff [3];
   logic signed [31:0]    sym_in [6], sym_ff [6];
   logic signed [31:0]    k4_ff [3];
   mat_type               mat_in, mat_ff;
   logic [BUILD_CNT_W-1:0] cnt_in, cnt_ff;

   always_comb begin
      omc_in    = sat32(ONE_Q30 - ext32(cfg.cosine));
      sq_in[0]  = 64'(cfg.axis_x) * 64'(cfg.axis_x);
      sq_in[1]  = 64'(cfg.axis_y) * 64'(cfg.axis_y);
      sq_in[2]  = 64'(cfg.axis_z) * 64'(cfg.axis_z);
      sq_in[3]  = 64'(cfg.axis_x) * 64'(cfg.axis_y);
      sq_in[4]  = 64'(cfg.axis_z) * 64'(cfg.axis_x);
      sq_in[5]  = 64'(cfg.axis_y) * 64'(cfg.axis_z);
      skp_in[0] = 64'(cfg.sine) * 64'(cfg.axis_x);
      skp_in[1] = 64'(cfg.sine) * 64'(cfg.axis_y);
      skp_in[2] = 64'(cfg.sine) * 64'(cfg.axis_z);
      for (int j = 0; j < 6; j++) begin
         q_in[j]    = round_sat(sq_ff[j]);
         symp_in[j] = 64'(q_ff[j]) * 64'(omc_ff);
         sym_in[j]  = round_sat(symp_ff[j]);
      end
      for (int i = 0; i < 3; i++) begin
         k2_in[i] = round_sat(skp_ff[i]);
      end
      mat_in[0][0] = sat32(ext32(cfg.cosine) + ext32(sym_ff[0]));
      mat_in[0][1] = sat32(ext32(sym_ff[3]) - ext32(k4_ff[2]));
      mat_in[0][2] = sat32(ext32(sym_ff[4]) + ext32(k4_ff[1]));
      mat_in[1][0] = sat32(ext32(sym_ff[3]) + ext32(k4_ff[2]));
      mat_in[1][1] = sat32(ext32(cfg.cosine) + ext32(sym_ff[1]));
      mat_in[1][2] = sat32(ext32(sym_ff[5]) - ext32(k4_ff[0]));
      mat_in[2][0] = sat32(ext32(sym_ff[4]) - ext32(k4_ff[1]));
      mat_in[2][1] = sat32(ext32(sym_ff[5]) + ext32(k4_ff[0]));
      mat_in[2][2] = sat32(ext32(cfg.cosine) + ext32(sym_ff[2]));
   end

   always_comb begin
      if (cfg_write) begin
         cnt_in = BUILD_CNT_W'(BUILD_STAGES);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      omc_ff <= omc_in;
      for (int j = 0; j < 6; j++) begin
         sq_ff[j]   <= sq_in[j];
         q_ff[j]    <= q_in[j];
         symp_ff[j] <= symp_in[j];
         sym_ff[j]  <= sym_in[j];
      end
      for (int i = 0; i < 3; i++) begin
         skp_ff[i] <= skp_in[i];
         k2_ff[i]  <= k2_in[i];
         k3_ff[i]  <= k2_ff[i];
         k4_ff[i]  <= k3_ff[i];
      end
      mat_ff <= mat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= BUILD_CNT_W'(BUILD_STAGES);
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign mat       = mat_ff;
   assign mat_ready = (cnt_ff == '0);

endmodule

// ===== hdl/avr_datapath.sv =====
// Three-stage vector pipeline: nine products, rounding, then row sums with
// saturation. Each stage holds a valid bit and stalls independently. Uses avr_pkg.

module avr_datapath import avr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  mat_type         mat,
   input  logic            mat_ready,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [95:0]     req_tdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [95:0]     rsp_tdata,
   output pipe_status_type status
);

   logic               rdy1, rdy2, rdy3;
   logic               v1_in, v1_ff, v2_in, v2_ff, v3_in, v3_ff;
   logic signed [63:0] prod_in [3][3], prod_ff [3][3];
   logic signed [33:0] rnd_in [3][3], rnd_ff [3][3];
   logic signed [31:0] rot_in [3], rot_ff [3];
   logic signed [31:0] vec [3];

   assign vec[0] = req_tdata[31:0];
   assign vec[1] = req_tdata[63:32];
   assign vec[2] = req_tdata[95:64];

   assign rdy3       = !v3_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1 && mat_ready;

   assign v1_in = rdy1 ? (req_tvalid && req_tready) : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = 64'($signed(mat[r][c])) * 64'(vec[c]);
            rnd_in[r][c]  = rnd30(prod_ff[r][c]);
         end
         rot_in[r] = sat32(ext34(rnd_ff[r][0]) + ext34(rnd_ff[r][1])
                           + ext34(rnd_ff[r][2]));
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         if (rdy1) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= prod_in[r][c];
            end
         end
         if (rdy2) begin
            for (int c = 0; c < 3; c++) begin
               rnd_ff[r][c] <= rnd_in[r][c];
            end
         end
         if (rdy3) begin
            rot_ff[r] <= rot_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign rsp_tvalid      = v3_ff;
   assign rsp_tdata       = {rot_ff[2], rot_ff[1], rot_ff[0]};
   assign status.s1_valid = v1_ff;
   assign status.s2_valid = v2_ff;

endmodule

// ===== hdl/axis_angle_vector_rotator.sv =====
// Channel   Direction  Handshake                   Payload
// req_      in         tvalid/tready               tdata: vec_x, vec_y, vec_z
// rsp_      out        tvalid/tready               tdata: rot_x, rot_y, rot_z
// csr_      in         psel/penable/pwrite/pready  five Q1.30 registers, 4-byte stride
//
// One item per cycle while the result side is ready and no rebuild runs; items pass
// the product, rounding and sum registers. The matrix is rebuilt by a five-stage pipeline;
// after reset and after each register write the block takes no item while it refills.
// Each pipeline stage stalls on its own, so bubbles close up behind a stalled result.
// Top level; depends on avr_pkg, avr_csr, avr_matrix and avr_datapath.

module axis_angle_vector_rotator import avr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [95:0]       req_tdata,   // vec_x [31:0], vec_y [63:32], vec_z [95:64]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [95:0]       rsp_tdata,   // rot_x [31:0], rot_y [63:32], rot_z [95:64]
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type         cfg;
   logic            cfg_write;
   mat_type         mat;
   logic            mat_ready;
   pipe_status_type status;

   avr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_write   (cfg_write)
   );

   avr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_write (cfg_write),
      .mat       (mat),
      .mat_ready (mat_ready)
   );

   avr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .mat        (mat),
      .mat_ready  (mat_ready),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .status     (status)
   );

   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("item intake open right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite) |=> !req_tready)
      else $error("item intake open while the matrix is rebuilt");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(status.s2_valid))
      else $error("result appeared without an item in the rounding stage");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> status.s1_valid)
      else $error("accepted item missing from the first stage");

endmodule

// ===== bench/tb_axis_angle_vector_rotator.sv =====
// Self-checking testbench for axis_angle_vector_rotator: a directed table, then random
// vectors under a series of register settings, checked against an in-bench predictor.
// Depends on avr_pkg and the axis_angle_vector_rotator RTL.

module tb_axis_angle_vector_rotator;
   import avr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REGS        = 5;
   localparam int LAST_SLOT       = 7;
   localparam int RANDOM_PHASES   = 11;
   localparam int PHASE_ITEMS     = 122;
   localparam int PRESSURE_PHASE  = 2;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int TAIL_CYCLES     = 16;
   localparam int WATCHDOG_LIMIT  = 2000;

   localparam logic [31:0] MAXV     = 32'h7FFF_FFFF;
   localparam logic [31:0] MINV     = 32'h8000_0000;
   localparam logic [31:0] ONE_BITS = 32'h4000_0000;
   localparam logic [31:0] NEG_ONE  = 32'hC000_0000;
   localparam longint UNITY_Q30 = 64'sd1073741824;
   localparam longint HALF_Q30  = 64'sd536870912;

   typedef struct packed {
      logic signed [31:0] z;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } vector3_type;

   typedef enum int {
      SET_RESET, SET_TURN_45_Z, SET_TURN_90_X, SET_TURN_180_Y, SET_TURN_60_DIAG,
      SET_ALL_LOW, SET_ALL_HIGH, SET_OVERRANGE, SET_RANDOM
   } setting_type;

   typedef enum int {STEP_KEEP, STEP_LOAD, STEP_STRAY} cfg_step_type;

   typedef struct {
      cfg_step_type step;
      setting_type  setting;
      vector3_type  vec;
      bit           typed;
      vector3_type  rot;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [95:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [95:0]       rsp_tdata;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   longint           register_copy [NUM_REGS];
   longint           rotation_matrix [3][3];
   vector3_type      pending_rotations [$];
   directed_row_type directed_rows [$];
   setting_type      phase_plan [RANDOM_PHASES] = '{
      SET_TURN_45_Z, SET_RANDOM, SET_TURN_90_X, SET_TURN_60_DIAG, SET_RANDOM,
      SET_TURN_180_Y, SET_ALL_LOW, SET_OVERRANGE, SET_ALL_HIGH, SET_RANDOM, SET_RESET
   };

   int error_count        = 0;
   int vectors_sent       = 0;
   int rotations_checked  = 0;
   int limit_components   = 0;
   int settings_applied   = 0;
   int stray_writes       = 0;
   int hold_offs_done     = 0;
   bit hold_off_pending   = 1'b0;

   axis_angle_vector_rotator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint round_q30(input longint p);
      return (p + HALF_Q30) >>> 30;
   endfunction

   function automatic void rebuild_matrix();
      longint sine;
      longint cosine;
      longint one_minus_cos;
      longint axis [3];
      longint sym [3][3];
      longint skew [3];
      int i;
      int j;
      sine = register_copy[REG_SINE];
      cosine = register_copy[REG_COSINE];
      axis[0] = register_copy[REG_AXIS_X];
      axis[1] = register_copy[REG_AXIS_Y];
      axis[2] = register_copy[REG_AXIS_Z];
      one_minus_cos = clamp32(UNITY_Q30 - cosine);
      for (i = 0; i < 3; i++) begin
         skew[i] = clamp32(round_q30(sine * axis[i]));
         for (j = 0; j < 3; j++) begin
            sym[i][j] = clamp32(round_q30(clamp32(round_q30(axis[i] * axis[j]))
                                          * one_minus_cos));
         end
         rotation_matrix[i][i] = clamp32(cosine + sym[i][i]);
      end
      rotation_matrix[0][1] = clamp32(sym[0][1] - skew[2]);
      rotation_matrix[1][0] = clamp32(sym[0][1] + skew[2]);
      rotation_matrix[0][2] = clamp32(sym[2][0] + skew[1]);
      rotation_matrix[2][0] = clamp32(sym[2][0] - skew[1]);
      rotation_matrix[1][2] = clamp32(sym[1][2] - skew[0]);
      rotation_matrix[2][1] = clamp32(sym[1][2] + skew[0]);
   endfunction

   function automatic vector3_type rotate_vector(input vector3_type v);
      longint comp [3];
      longint acc [3];
      int row;
      vector3_type r;
      comp[0] = longint'(v.x);
      comp[1] = longint'(v.y);
      comp[2] = longint'(v.z);
      for (row = 0; row < 3; row++) begin
         acc[row] = clamp32(round_q30(rotation_matrix[row][0] * comp[0])
                          + round_q30(rotation_matrix[row][1] * comp[1])
                          + round_q30(rotation_matrix[row][2] * comp[2]));
      end
      r.x = acc[0][31:0];
      r.y = acc[1][31:0];
      r.z = acc[2][31:0];
      return r;
   endfunction

   function automatic string register_name(input logic [2:0] slot);
      case (slot)
         REG_SINE:   return "sine_of_angle";
         REG_COSINE: return "cosine_of_angle";
         REG_AXIS_X: return "axis_x";
         REG_AXIS_Y: return "axis_y";
         REG_AXIS_Z: return "axis_z";
         default:    return "unmapped";
      endcase
   endfunction

   function automatic cfg_type make_setting(input logic [31:0] s, c, ax, ay, az);
      cfg_type v;
      v.sine = s;
      v.cosine = c;
      v.axis_x = ax;
      v.axis_y = ay;
      v.axis_z = az;
      return v;
   endfunction

   function automatic logic [31:0] random_register();
      logic [31:0] r;
      if ($urandom_range(0, 1) == 0) begin
         r = $urandom();
      end else begin
         r = $urandom_range(0, 32'h8000_0000) - ONE_BITS;
      end
      return r;
   endfunction

   function automatic cfg_type setting_values(input setting_type which);
      case (which)
         SET_RESET:        return make_setting(0, ONE_BITS, 0, 0, ONE_BITS);
         SET_TURN_45_Z:    return make_setting(32'd759250125, 32'd759250125, 0, 0, ONE_BITS);
         SET_TURN_90_X:    return make_setting(ONE_BITS, 0, ONE_BITS, 0, 0);
         SET_TURN_180_Y:   return make_setting(0, NEG_ONE, 0, ONE_BITS, 0);
         SET_TURN_60_DIAG: return make_setting(32'd929887697, 32'd536870912, 32'd619925131,
                                               32'd619925131, 32'd619925131);
         SET_ALL_LOW:      return make_setting(NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE);
         SET_ALL_HIGH:     return make_setting(ONE_BITS, ONE_BITS, ONE_BITS, ONE_BITS,
                                               ONE_BITS);
         SET_OVERRANGE:    return make_setting(MAXV, MINV, MINV, MAXV, MINV);
         default:          return make_setting(random_register(), random_register(),
                                               random_register(), random_register(),
                                               random_register());
      endcase
   endfunction

   function automatic logic [31:0] random_component();
      logic [31:0] r;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0:       r = MAXV;
               1:       r = MINV;
               2:       r = 32'h0;
               3:       r = 32'h1;
               default: r = 32'hFFFF_FFFF;
            endcase
         end
         1, 2, 3: r = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         default: r = $urandom();
      endcase
      return r;
   endfunction

   function automatic void add_row(input cfg_step_type step, input setting_type setting,
                                   input logic [31:0] x, y, z, input bit typed,
                                   input logic [31:0] rx, ry, rz);
      directed_row_type row;
      row.step = step;
      row.setting = setting;
      row.vec.x = x;
      row.vec.y = y;
      row.vec.z = z;
      row.typed = typed;
      row.rot.x = rx;
      row.rot.y = ry;
      row.rot.z = rz;
      directed_rows.push_back(row);
   endfunction

   task automatic csr_access(input logic [2:0] slot, input bit is_write,
                             input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {slot, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         if (slot < NUM_REGS) begin
            register_copy[slot] = longint'($signed(value));
            rebuild_matrix();
         end
      end else if (csr_prdata !== register_copy[slot][31:0]) begin
         $error("%s readback expected %h actual %h", register_name(slot),
                register_copy[slot][31:0], csr_prdata);
         error_count++;
      end
   endtask

   task automatic csr_bus_idle();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_back_all();
      int slot;
      for (slot = 0; slot < NUM_REGS; slot++) begin
         csr_access(slot[2:0], 1'b0, 32'h0);
      end
   endtask

   task automatic apply_setting(input cfg_type s);
      csr_access(REG_SINE, 1'b1, s.sine);
      csr_access(REG_COSINE, 1'b1, s.cosine);
      csr_access(REG_AXIS_X, 1'b1, s.axis_x);
      csr_access(REG_AXIS_Y, 1'b1, s.axis_y);
      csr_access(REG_AXIS_Z, 1'b1, s.axis_z);
      read_back_all();
      csr_bus_idle();
      settings_applied++;
   endtask

   task automatic write_unmapped_slots();
      int slot;
      for (slot = NUM_REGS; slot <= LAST_SLOT; slot++) begin
         csr_access(slot[2:0], 1'b1, $urandom());
         stray_writes++;
      end
      csr_bus_idle();
   endtask

   task automatic wait_for_drain();
      while (pending_rotations.size() != 0) @(posedge clock);
   endtask

   task automatic push_vector(input vector3_type v, input vector3_type want);
      req_tvalid <= 1'b1;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      pending_rotations.push_back(want);
      vectors_sent++;
   endtask

   task automatic stream_random(input int count);
      int left;
      int burst;
      int gap;
      vector3_type v;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) begin
            burst = left;
         end
         repeat (burst) begin
            v.x = random_component();
            v.y = random_component();
            v.z = random_component();
            push_vector(v, rotate_vector(v));
         end
         left -= burst;
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic check_component(input string field, input logic [31:0] want, got);
      if (want == MAXV || want == MINV) begin
         limit_components++;
      end
      if (got !== want) begin
         $error("%s expected %0d actual %0d", field, $signed(want), $signed(got));
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_rotations
      vector3_type want;
      vector3_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = vector3_type'(rsp_tdata);
         if (pending_rotations.size() == 0) begin
            $error("rotated vector %h arrived with none expected", rsp_tdata);
            error_count++;
         end else begin
            want = pending_rotations.pop_front();
            check_component("rot_x", want.x, got.x);
            check_component("rot_y", want.y, got.y);
            check_component("rot_z", want.z, got.z);
            rotations_checked++;
         end
      end
   end

   initial begin : result_side
      int mode;
      int run;
      forever begin
         if (hold_off_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_pending = 1'b0;
            hold_offs_done++;
         end else begin
            mode = $urandom_range(0, 3);
            run = (mode == 1) ? $urandom_range(1, 8) : $urandom_range(1, 32);
            repeat (run) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'b0;
                  default: rsp_tready <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
               || (csr_psel && csr_penable)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int phase;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;

      // Identity rows after reset and 90-degree x rows typed; the rest predicted.
      add_row(STEP_KEEP, SET_RESET, 0, 0, 0, 1, 0, 0, 0);
      add_row(STEP_KEEP, SET_RESET, MAXV, MAXV, MAXV, 1, MAXV, MAXV, MAXV);
      add_row(STEP_KEEP, SET_RESET, MINV, MINV, MINV, 1, MINV, MINV, MINV);
      add_row(STEP_KEEP, SET_RESET, 1, 32'hFFFF_FFFF, 0, 1, 1, 32'hFFFF_FFFF, 0);
      add_row(STEP_KEEP, SET_RESET, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_8000,
              1, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_8000);
      add_row(STEP_KEEP, SET_RESET, MINV, MAXV, 32'hFFFF_FFFF,
              1, MINV, MAXV, 32'hFFFF_FFFF);
      add_row(STEP_KEEP, SET_RESET, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
              1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
      add_row(STEP_LOAD, SET_TURN_45_Z, MAXV, MAXV, 0, 0, 0, 0, 0);
      add_row(STEP_KEEP, SET_TURN_45_Z, MINV, MINV, MAXV, 0, 0, 0, 0);
      add_row(STEP_KEEP, SET_TURN_45_Z, MAXV, MINV, MINV, 0, 0, 0, 0);
      add_row(STEP_KEEP, SET_TURN_45_Z, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
      add_row(STEP_STRAY, SET_TURN_45_Z, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              0, 0, 0, 0);
      add_row(STEP_LOAD, SET_TURN_90_X, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              1, 32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
      add_row(STEP_KEEP, SET_TURN_90_X, 1, 2, MINV, 1, 1, MAXV, 2);
      add_row(STEP_LOAD, SET_OVERRANGE, MAXV, MINV, MAXV, 0, 0, 0, 0);
      add_row(STEP_KEEP, SET_OVERRANGE, 32'hFFFF_FFFF, 1, 32'h1234_5678, 0, 0, 0, 0);
      add_row(STEP_LOAD, SET_ALL_LOW, MAXV, MAXV, MAXV, 0, 0, 0, 0);
      add_row(STEP_LOAD, SET_ALL_HIGH, MINV, 0, MAXV, 0, 0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      register_copy[REG_SINE]   = 0;
      register_copy[REG_COSINE] = UNITY_Q30;
      register_copy[REG_AXIS_X] = 0;
      register_copy[REG_AXIS_Y] = 0;
      register_copy[REG_AXIS_Z] = UNITY_Q30;
      rebuild_matrix();
      read_back_all();
      csr_bus_idle();

      foreach (directed_rows[i]) begin
         if (directed_rows[i].step != STEP_KEEP) begin
            req_tvalid <= 1'b0;
            wait_for_drain();
            if (directed_rows[i].step == STEP_LOAD) begin
               apply_setting(setting_values(directed_rows[i].setting));
            end else begin
               write_unmapped_slots();
            end
         end
         push_vector(directed_rows[i].vec, directed_rows[i].typed ? directed_rows[i].rot
                                           : rotate_vector(directed_rows[i].vec));
      end
      req_tvalid <= 1'b0;

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain();
         apply_setting(setting_values(phase_plan[phase]));
         if (phase == PRESSURE_PHASE) begin
            hold_off_pending = 1'b1;
         end
         stream_random(PHASE_ITEMS);
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d vectors under %0d register settings, %0d writes to unmapped slots,",
               vectors_sent, settings_applied, stray_writes);
      $display("checked %0d rotations (%0d components at a clamp limit), %0d long hold-offs.",
               rotations_checked, limit_components, hold_offs_done);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
